>>> design/ps2m_pkg.sv
// Shared types and protocol constants of the PS/2 mouse command engine.
`default_nettype none
package ps2m_pkg;

   // Bytes sent to the host.
   localparam logic [7:0] BYTE_ACK    = 8'hFA;
   localparam logic [7:0] BYTE_RESEND = 8'hFE;
   localparam logic [7:0] BYTE_BAT    = 8'hAA;
   localparam logic [7:0] BYTE_ID_STD = 8'h00;
   localparam logic [7:0] BYTE_ID_WHL = 8'h03;

   // Bits of the first packet byte.
   localparam logic [7:0] PKT_ALWAYS_ONE = 8'h08;

   // Host commands.
   localparam logic [7:0] CMD_SCALE_1TO1 = 8'hE6;
   localparam logic [7:0] CMD_SCALE_2TO1 = 8'hE7;
   localparam logic [7:0] CMD_SET_RES    = 8'hE8;
   localparam logic [7:0] CMD_STATUS     = 8'hE9;
   localparam logic [7:0] CMD_STREAM     = 8'hEA;
   localparam logic [7:0] CMD_READ_DATA  = 8'hEB;
   localparam logic [7:0] CMD_RESET_WRAP = 8'hEC;
   localparam logic [7:0] CMD_WRAP       = 8'hEE;
   localparam logic [7:0] CMD_REMOTE     = 8'hF0;
   localparam logic [7:0] CMD_GET_ID     = 8'hF2;
   localparam logic [7:0] CMD_SET_RATE   = 8'hF3;
   localparam logic [7:0] CMD_ENABLE     = 8'hF4;
   localparam logic [7:0] CMD_DISABLE    = 8'hF5;
   localparam logic [7:0] CMD_DEFAULTS   = 8'hF6;
   localparam logic [7:0] CMD_RESET      = 8'hFF;

   // Pending parameter codes.
   localparam logic [1:0] PEND_NONE = 2'd0;
   localparam logic [1:0] PEND_RES  = 2'd1;
   localparam logic [1:0] PEND_RATE = 2'd2;

   // Steps of the wheel detection sequence.
   localparam logic [1:0] HS_IDLE    = 2'd0;
   localparam logic [1:0] HS_SAW_200 = 2'd1;
   localparam logic [1:0] HS_SAW_100 = 2'd2;

   localparam logic [7:0] RATE_HS_FIRST  = 8'd200;
   localparam logic [7:0] RATE_HS_SECOND = 8'd100;
   localparam logic [7:0] RATE_HS_THIRD  = 8'd80;

   localparam logic [1:0] RES_DEFAULT  = 2'd2;
   localparam logic [7:0] RATE_DEFAULT = 8'd100;
   localparam logic [7:0] RES_MAX      = 8'd3;

   localparam int MAX_REPLY = 5;

   // One reply as it travels from the front end to the byte sender.
   typedef struct packed {
      logic            is_pkt;
      logic            ack_first;
      logic            wheel;
      logic            scale;
      logic [2:0]      buttons;
      logic [2:0]      lit_count;
      logic [3:0][7:0] lit;
   } ctl_type;

   function automatic logic rate_ok(input logic [7:0] r);
      return (r == 8'd10) || (r == 8'd20) || (r == 8'd40) || (r == 8'd60) ||
             (r == 8'd80) || (r == 8'd100) || (r == 8'd200);
   endfunction

endpackage
`default_nettype wire

>>> design/ps2_mouse_command_engine_top.sv
// Top level of the PS/2 mouse command engine (device side, with wheel extension).
//
// The req channel carries one word per item: tuser says whether it is a host byte (0)
// or a sensor event (1); tdata holds the host byte and the event's counts and buttons.
// The rsp channel carries the reply bytes the device sends to the host; tlast marks the
// final byte of each item's reply. An item that causes no reply (an event while
// reporting is off, or in remote mode) sends nothing.
// A word is accepted while req_tready is high and its reply is queued; the first reply
// byte passes through the queue and then the sender's byte register before it is shown.
// The sender moves one byte per cycle while rsp_tready is high; a reply has one to five
// bytes. Items enter back to back while the reply queue of QUEUE_DEPTH entries has room.
// Reset, synchronous and active high, restores the power-on modes, clears the
// movement counts and empties the queue. When rsp_tready is held low the current byte
// stays on the port, the queue fills and req_tready falls once it is full.
`default_nettype none
module ps2_mouse_command_engine_top #(
   parameter int ACC_WIDTH   = 16,
   parameter int MOVE_WIDTH  = 12,
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   // From bit 0 up: host_byte, move_dx, move_dy, move_dz, buttons_in, zero padding.
   input  wire logic [((2*MOVE_WIDTH+26)/8)*8-1:0]     req_tdata,
   // opcode
   input  wire logic                                   req_tuser,
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   // tx_byte
   output logic [7:0]                                  rsp_tdata,
   output logic                                        rsp_tlast
);
   import ps2m_pkg::*;

   localparam int CTL_W = $bits(ctl_type);
   localparam int QW    = CTL_W + 3 * ACC_WIDTH;

   logic                 accept;
   logic                 push, full, pop, empty;
   ctl_type              push_ctl, head_ctl;
   logic [ACC_WIDTH-1:0] push_x, push_y, push_z;
   logic [ACC_WIDTH-1:0] head_x, head_y, head_z;
   logic [QW-1:0]        head_word;

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   ps2m_front #(
      .ACC_WIDTH  (ACC_WIDTH),
      .MOVE_WIDTH (MOVE_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .opcode     (req_tuser),
      .host_byte  (req_tdata[7:0]),
      .move_dx    (req_tdata[8 +: MOVE_WIDTH]),
      .move_dy    (req_tdata[8+MOVE_WIDTH +: MOVE_WIDTH]),
      .move_dz    (req_tdata[8+2*MOVE_WIDTH +: 8]),
      .buttons_in (req_tdata[16+2*MOVE_WIDTH +: 3]),
      .push       (push),
      .push_ctl   (push_ctl),
      .push_x     (push_x),
      .push_y     (push_y),
      .push_z     (push_z)
   );

   ps2m_fifo #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_ctl, push_x, push_y, push_z}),
      .full      (full),
      .pop       (pop),
      .pop_data  (head_word),
      .empty     (empty)
   );

   assign head_ctl = head_word[QW-1 -: CTL_W];
   assign head_x   = head_word[3*ACC_WIDTH-1 -: ACC_WIDTH];
   assign head_y   = head_word[2*ACC_WIDTH-1 -: ACC_WIDTH];
   assign head_z   = head_word[ACC_WIDTH-1:0];

   ps2m_back #(
      .ACC_WIDTH (ACC_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .empty      (empty),
      .head_ctl   (head_ctl),
      .head_x     (head_x),
      .head_y     (head_y),
      .head_z     (head_z),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // The sender never takes a reply from an empty queue.
   assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("reply taken from an empty queue");

   // A queued reply is on the port by the next cycle.
   assert property (@(posedge clock) disable iff (reset) !empty |=> rsp_tvalid)
      else $error("queued reply not presented");

   // A reply run has no gaps between its bytes.
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_tvalid && rsp_tready && !rsp_tlast) |=> rsp_tvalid)
      else $error("reply run broken before its last byte");

endmodule
`default_nettype wire

>>> design/ps2m_front.sv
// Front end: takes host bytes and sensor events, keeps the mouse state, queues replies.
`default_nettype none
module ps2m_front #(
   parameter int ACC_WIDTH  = 16,
   parameter int MOVE_WIDTH = 12
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        accept,
   input  wire logic                        opcode,
   input  wire logic [7:0]                  host_byte,
   input  wire logic [MOVE_WIDTH-1:0]       move_dx,
   input  wire logic [MOVE_WIDTH-1:0]       move_dy,
   input  wire logic [7:0]                  move_dz,
   input  wire logic [2:0]                  buttons_in,
   output logic                             push,
   output ps2m_pkg::ctl_type                push_ctl,
   output logic [ACC_WIDTH-1:0]             push_x,
   output logic [ACC_WIDTH-1:0]             push_y,
   output logic [ACC_WIDTH-1:0]             push_z
);
   import ps2m_pkg::*;

   localparam int SW = ((ACC_WIDTH > MOVE_WIDTH) ? ACC_WIDTH : MOVE_WIDTH) + 1;
   localparam logic signed [SW-1:0] AMAX =
      {{(SW-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
   localparam logic signed [SW-1:0] AMIN =
      {{(SW-ACC_WIDTH+1){1'b1}}, {(ACC_WIDTH-1){1'b0}}};

   logic                 enabled_ff, enabled_in;
   logic                 remote_ff, remote_in;
   logic                 wrap_ff, wrap_in;
   logic                 scale_ff, scale_in;
   logic [1:0]           res_ff, res_in;
   logic [7:0]           rate_ff, rate_in;
   logic                 wheel_id_ff, wheel_id_in;
   logic [1:0]           hs_step_ff, hs_step_in;
   logic [1:0]           pend_ff, pend_in;
   logic [2:0]           btn_ff, btn_in;
   logic [ACC_WIDTH-1:0] acc_x_ff, acc_x_in;
   logic [ACC_WIDTH-1:0] acc_y_ff, acc_y_in;
   logic [ACC_WIDTH-1:0] acc_z_ff, acc_z_in;

   logic [ACC_WIDTH-1:0] sat_x, sat_y, sat_z;
   logic [7:0]           status;

   function automatic logic [ACC_WIDTH-1:0] sat_add(input logic [ACC_WIDTH-1:0] a,
                                                    input logic [SW-1:0] d);
      logic signed [SW-1:0] sum;
      sum = $signed({{(SW-ACC_WIDTH){a[ACC_WIDTH-1]}}, a}) + $signed(d);
      if (sum > AMAX) begin
         return AMAX[ACC_WIDTH-1:0];
      end else if (sum < AMIN) begin
         return AMIN[ACC_WIDTH-1:0];
      end
      return sum[ACC_WIDTH-1:0];
   endfunction

   assign sat_x = sat_add(acc_x_ff, {{(SW-MOVE_WIDTH){move_dx[MOVE_WIDTH-1]}}, move_dx});
   assign sat_y = sat_add(acc_y_ff, {{(SW-MOVE_WIDTH){move_dy[MOVE_WIDTH-1]}}, move_dy});
   assign sat_z = sat_add(acc_z_ff, {{(SW-8){move_dz[7]}}, move_dz});

   // Status byte: mode bits, then the left, middle and right buttons in that odd order.
   assign status = {1'b0, remote_ff, enabled_ff, scale_ff, 1'b0,
                    btn_ff[0], btn_ff[2], btn_ff[1]};

   // A poll reports the stored counts; an event reports the freshly summed ones.
   assign push_x = opcode ? sat_x : acc_x_ff;
   assign push_y = opcode ? sat_y : acc_y_ff;
   assign push_z = opcode ? sat_z : acc_z_ff;

   always_comb begin
      enabled_in  = enabled_ff;
      remote_in   = remote_ff;
      wrap_in     = wrap_ff;
      scale_in    = scale_ff;
      res_in      = res_ff;
      rate_in     = rate_ff;
      wheel_id_in = wheel_id_ff;
      hs_step_in  = hs_step_ff;
      pend_in     = pend_ff;
      btn_in      = btn_ff;
      acc_x_in    = acc_x_ff;
      acc_y_in    = acc_y_ff;
      acc_z_in    = acc_z_ff;
      push        = 1'b0;
      push_ctl    = '0;
      push_ctl.wheel   = wheel_id_ff;
      push_ctl.buttons = btn_ff;

      if (accept) begin
         if (opcode) begin
            btn_in = buttons_in;
            push_ctl.buttons = buttons_in;
            if (enabled_ff) begin
               acc_x_in = sat_x;
               acc_y_in = sat_y;
               acc_z_in = sat_z;
               if (!remote_ff) begin
                  push            = 1'b1;
                  push_ctl.is_pkt = 1'b1;
                  push_ctl.scale  = scale_ff;
                  acc_x_in = '0;
                  acc_y_in = '0;
                  acc_z_in = '0;
               end
            end
         end else begin
            push = 1'b1;
            push_ctl.lit_count = 3'd1;
            push_ctl.lit[0]    = BYTE_ACK;
            if (wrap_ff && host_byte != CMD_RESET) begin
               if (host_byte == CMD_RESET_WRAP) begin
                  wrap_in = 1'b0;
               end
               push_ctl.lit[0] = host_byte;
            end else if (pend_ff == PEND_RES) begin
               pend_in = PEND_NONE;
               if (host_byte > RES_MAX) begin
                  push_ctl.lit[0] = BYTE_RESEND;
               end else begin
                  res_in = host_byte[1:0];
               end
            end else if (pend_ff == PEND_RATE) begin
               pend_in = PEND_NONE;
               if (!rate_ok(host_byte)) begin
                  push_ctl.lit[0] = BYTE_RESEND;
               end else begin
                  rate_in = host_byte;
                  // Wheel detection: rates 200, 100 and 80 in a row.
                  if (hs_step_ff == HS_IDLE) begin
                     if (host_byte == RATE_HS_FIRST) begin
                        hs_step_in = HS_SAW_200;
                     end
                  end else if (hs_step_ff == HS_SAW_200) begin
                     hs_step_in = (host_byte == RATE_HS_SECOND) ? HS_SAW_100 : HS_IDLE;
                  end else begin
                     if (host_byte == RATE_HS_THIRD) begin
                        wheel_id_in = 1'b1;
                     end
                     hs_step_in = HS_IDLE;
                  end
               end
            end else begin
               pend_in = PEND_NONE;
               unique case (host_byte)
                  CMD_SCALE_1TO1: scale_in = 1'b0;
                  CMD_SCALE_2TO1: scale_in = 1'b1;
                  CMD_SET_RES:    pend_in  = PEND_RES;
                  CMD_SET_RATE:   pend_in  = PEND_RATE;
                  CMD_STATUS: begin
                     push_ctl.lit_count = 3'd4;
                     push_ctl.lit[1]    = status;
                     push_ctl.lit[2]    = {6'd0, res_ff};
                     push_ctl.lit[3]    = rate_ff;
                  end
                  CMD_STREAM:     remote_in = 1'b0;
                  CMD_READ_DATA: begin
                     push_ctl.is_pkt    = 1'b1;
                     push_ctl.ack_first = 1'b1;
                     push_ctl.lit_count = 3'd0;
                     acc_x_in = '0;
                     acc_y_in = '0;
                     acc_z_in = '0;
                  end
                  CMD_WRAP:       wrap_in   = 1'b1;
                  CMD_REMOTE:     remote_in = 1'b1;
                  CMD_GET_ID: begin
                     push_ctl.lit_count = 3'd2;
                     push_ctl.lit[1]    = wheel_id_ff ? BYTE_ID_WHL : BYTE_ID_STD;
                  end
                  CMD_ENABLE:     enabled_in = 1'b1;
                  CMD_DISABLE:    enabled_in = 1'b0;
                  CMD_DEFAULTS: begin
                     enabled_in = 1'b0;
                     remote_in  = 1'b0;
                     scale_in   = 1'b0;
                     rate_in    = RATE_DEFAULT;
                     res_in     = RES_DEFAULT;
                  end
                  CMD_RESET: begin
                     enabled_in  = 1'b0;
                     remote_in   = 1'b0;
                     scale_in    = 1'b0;
                     rate_in     = RATE_DEFAULT;
                     res_in      = RES_DEFAULT;
                     wrap_in     = 1'b0;
                     wheel_id_in = 1'b0;
                     hs_step_in  = HS_IDLE;
                     btn_in      = 3'd0;
                     acc_x_in    = '0;
                     acc_y_in    = '0;
                     acc_z_in    = '0;
                     push_ctl.lit_count = 3'd3;
                     push_ctl.lit[1]    = BYTE_BAT;
                     push_ctl.lit[2]    = BYTE_ID_STD;
                  end
                  default:        push_ctl.lit[0] = BYTE_RESEND;
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff  <= 1'b0;
         remote_ff   <= 1'b0;
         wrap_ff     <= 1'b0;
         scale_ff    <= 1'b0;
         res_ff      <= RES_DEFAULT;
         rate_ff     <= RATE_DEFAULT;
         wheel_id_ff <= 1'b0;
         hs_step_ff  <= HS_IDLE;
         pend_ff     <= PEND_NONE;
         btn_ff      <= 3'd0;
         acc_x_ff    <= '0;
         acc_y_ff    <= '0;
         acc_z_ff    <= '0;
      end else begin
         enabled_ff  <= enabled_in;
         remote_ff   <= remote_in;
         wrap_ff     <= wrap_in;
         scale_ff    <= scale_in;
         res_ff      <= res_in;
         rate_ff     <= rate_in;
         wheel_id_ff <= wheel_id_in;
         hs_step_ff  <= hs_step_in;
         pend_ff     <= pend_in;
         btn_ff      <= btn_in;
         acc_x_ff    <= acc_x_in;
         acc_y_ff    <= acc_y_in;
         acc_z_ff    <= acc_z_in;
      end
   end

endmodule
`default_nettype wire

>>> design/ps2m_fifo.sv
// Short reply queue between the front end and the byte sender.
`default_nettype none
module ps2m_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    level_ff, level_in;

   assign full     = (level_ff == CW'(DEPTH));
   assign empty    = (level_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (pop && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

endmodule
`default_nettype wire

>>> design/ps2m_back.sv
// Byte sender: formats each queued reply into bytes and sends them one a cycle while rsp_tready is high.
`default_nettype none
module ps2m_back #(
   parameter int ACC_WIDTH = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 empty,
   input  wire ps2m_pkg::ctl_type    head_ctl,
   input  wire logic [ACC_WIDTH-1:0] head_x,
   input  wire logic [ACC_WIDTH-1:0] head_y,
   input  wire logic [ACC_WIDTH-1:0] head_z,
   output logic                      pop,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [7:0]                rsp_tdata,
   output logic                      rsp_tlast
);
   import ps2m_pkg::*;

   localparam int EW = ACC_WIDTH + 1;

   logic       busy_ff, busy_in;
   logic [2:0] idx_ff, idx_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [7:0] byte_ff [MAX_REPLY];
   logic [7:0] fmt_byte [MAX_REPLY];
   logic [2:0] fmt_cnt;

   logic [EW-1:0] val_x, val_y;
   logic          ovf_x, ovf_y;
   logic [7:0]    lo_x, lo_y;
   logic [7:0]    pkt_b0;
   logic          take, finish;

   // 2:1 scaling curve, one step wider than the counts.
   function automatic logic [EW-1:0] scale21(input logic [ACC_WIDTH-1:0] n);
      logic [EW-1:0] e;
      e = {n[ACC_WIDTH-1], n};
      if (n == ACC_WIDTH'(2)) begin
         return EW'(1);
      end else if (n == ACC_WIDTH'(-2)) begin
         return EW'(-1);
      end else if (n == ACC_WIDTH'(4)) begin
         return EW'(6);
      end else if (n == ACC_WIDTH'(-4)) begin
         return EW'(-6);
      end else if (n == ACC_WIDTH'(5)) begin
         return EW'(9);
      end else if (n == ACC_WIDTH'(-5)) begin
         return EW'(-9);
      end else if (n == '0 || n == ACC_WIDTH'(1) || n == ACC_WIDTH'(-1) ||
                   n == ACC_WIDTH'(3) || n == ACC_WIDTH'(-3)) begin
         return e;
      end
      return {e[EW-2:0], 1'b0};
   endfunction

   // Nine-bit range check: all bits from bit 8 up must match the sign.
   function automatic logic out_of_range(input logic [EW-1:0] v);
      return v[EW-1:8] != {(EW-8){v[EW-1]}};
   endfunction

   function automatic logic [7:0] clamp_low(input logic [EW-1:0] v);
      if (out_of_range(v)) begin
         return v[EW-1] ? 8'h00 : 8'hFF;
      end
      return v[7:0];
   endfunction

   assign val_x = head_ctl.scale ? scale21(head_x) : {head_x[ACC_WIDTH-1], head_x};
   assign val_y = head_ctl.scale ? scale21(head_y) : {head_y[ACC_WIDTH-1], head_y};
   assign ovf_x = out_of_range(val_x);
   assign ovf_y = out_of_range(val_y);
   assign lo_x  = clamp_low(val_x);
   assign lo_y  = clamp_low(val_y);
   assign pkt_b0 = PKT_ALWAYS_ONE | {ovf_y, ovf_x, val_y[EW-1], val_x[EW-1], 1'b0,
                                     head_ctl.buttons};

   always_comb begin
      fmt_byte[0] = head_ctl.lit[0];
      fmt_byte[1] = head_ctl.lit[1];
      fmt_byte[2] = head_ctl.lit[2];
      fmt_byte[3] = head_ctl.lit[3];
      fmt_byte[4] = head_z[7:0];
      fmt_cnt     = head_ctl.lit_count;
      if (head_ctl.is_pkt) begin
         fmt_cnt = 3'd3 + {2'd0, head_ctl.ack_first} + {2'd0, head_ctl.wheel};
         if (head_ctl.ack_first) begin
            fmt_byte[0] = BYTE_ACK;
            fmt_byte[1] = pkt_b0;
            fmt_byte[2] = lo_x;
            fmt_byte[3] = lo_y;
         end else begin
            fmt_byte[0] = pkt_b0;
            fmt_byte[1] = lo_x;
            fmt_byte[2] = lo_y;
            fmt_byte[3] = head_z[7:0];
         end
      end
   end

   assign rsp_tvalid = busy_ff;
   assign rsp_tdata  = byte_ff[idx_ff];
   assign rsp_tlast  = (idx_ff == cnt_ff - 3'd1);
   assign take       = busy_ff && rsp_tready;
   assign finish     = take && rsp_tlast;
   // The next reply is loaded when the sender is idle or in the cycle the last byte of the current one leaves.
   assign pop        = !empty && (!busy_ff || finish);

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      cnt_in  = cnt_ff;
      if (pop) begin
         busy_in = 1'b1;
         idx_in  = 3'd0;
         cnt_in  = fmt_cnt;
      end else if (finish) begin
         busy_in = 1'b0;
      end else if (take) begin
         idx_in = idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         for (int i = 0; i < MAX_REPLY; i++) begin
            byte_ff[i] <= fmt_byte[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 3'd0;
         cnt_ff  <= 3'd1;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule
`default_nettype wire
